### rtl/cei_pkg.sv
// shared types, codes and helpers for the console escape interpreter
// no dependencies; imported by every module of the block
package cei_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] PROTO_ESCAPE = 8'hFF;

    // configuration register indexes
    localparam logic [2:0] REG_ESCAPE_CHAR     = 3'd0;
    localparam logic [2:0] REG_INITIAL_MONITOR = 3'd1;
    localparam logic [2:0] REG_BROADCAST_ON    = 3'd2;
    localparam logic [2:0] REG_RESET_ALLOWED   = 3'd3;
    localparam logic [2:0] REG_ECHO_INITIAL    = 3'd4;
    localparam logic [2:0] REG_QUIET_INITIAL   = 3'd5;

    localparam logic [7:0] ESCAPE_CHAR_RST = 8'd38;

    // command characters
    localparam logic [7:0] CMD_BREAK   = 8'h42;
    localparam logic [7:0] CMD_CLOSE   = 8'h2E;
    localparam logic [7:0] CMD_DEL     = 8'h44;
    localparam logic [7:0] CMD_ECHO    = 8'h45;
    localparam logic [7:0] CMD_FORCE   = 8'h46;
    localparam logic [7:0] CMD_HELP    = 8'h3F;
    localparam logic [7:0] CMD_INFO    = 8'h49;
    localparam logic [7:0] CMD_JOIN    = 8'h4A;
    localparam logic [7:0] CMD_REPLAY  = 8'h4C;
    localparam logic [7:0] CMD_MONITOR = 8'h4D;
    localparam logic [7:0] CMD_QUIET   = 8'h51;
    localparam logic [7:0] CMD_RESET   = 8'h52;
    localparam logic [7:0] CMD_SUSPEND = 8'h5A;

    // local action codes
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_CLOSE   = 3'd1;
    localparam logic [2:0] ACT_HELP    = 3'd2;
    localparam logic [2:0] ACT_INFO    = 3'd3;
    localparam logic [2:0] ACT_SUSPEND = 3'd4;
    localparam logic [2:0] ACT_ECHO    = 3'd5;
    localparam logic [2:0] ACT_DONE    = 3'd6;

    // privilege request codes
    localparam logic [1:0] PRIV_NONE  = 2'd0;
    localparam logic [1:0] PRIV_FORCE = 2'd1;
    localparam logic [1:0] PRIV_JOIN  = 2'd2;

    typedef struct packed {
        logic [7:0] typed_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic       send_valid;
        logic [7:0] send_byte;
        logic [2:0] local_action;
        logic       write_mode;
        logic       echo_on;
        logic       quiet_on;
        logic [1:0] privilege;
        logic       last;
    } out_item_t;

    // one classified item: up to four bytes to send plus the status after it
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
        logic [2:0]      action;
        logic            mode;
        logic            echo;
        logic            quiet;
        logic [1:0]      priv;
    } job_t;

endpackage

### rtl/console_escape_interpreter.sv
// top level of the console escape interpreter: front end, job queue, back end
// depends on cei_pkg, cei_front, cei_queue and cei_back
//
//  channel | direction | handshake             | payload
//  in      | in        | in_valid / in_ready   | in_data: typed_byte, end_of_input
//  out     | out       | out_valid / out_ready | out_data: one result per byte sent, or one if none
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data (8 bits)
//
// an item yields 1 to 4 results; the back end gives one result per cycle while
// out_ready is high, so the output port sets the rate
// the front end takes a new item every cycle while the job queue has room
// out_valid for the first result rises once the item reaches the back end register
// reset is asynchronous active low and loads the register reset values; cfg_ready
// is always high
module console_escape_interpreter #(
    parameter int unsigned QUEUE_DEPTH = cei_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  cei_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output cei_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [7:0]         cfg_data
);
    import cei_pkg::*;

    logic front_valid;
    logic front_ready;
    job_t front_job;
    logic back_valid;
    logic back_ready;
    job_t back_job;

    assign cfg_ready = 1'b1;

    cei_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .job_valid (front_valid),
        .job_ready (front_ready),
        .job       (front_job)
    );

    cei_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_job   (front_job),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_job    (back_job)
    );

    cei_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (back_valid),
        .job_ready (back_ready),
        .job       (back_job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

### rtl/cei_front.sv
// front end: takes typed bytes, keeps session state and config, classifies
// each transaction into a job for the back end; depends on cei_pkg
module cei_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cei_pkg::in_item_t in_data,
    input  logic              cfg_valid,
    input  logic [2:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    output logic              job_valid,
    input  logic              job_ready,
    output cei_pkg::job_t     job
);
    import cei_pkg::*;

    logic [7:0] esc_reg;
    logic       broadcast_reg;
    logic       reset_allowed_reg;

    logic       pend_reg,   pend_next;
    logic       mode_reg,   mode_next;
    logic       echo_reg,   echo_next;
    logic       quiet_reg,  quiet_next;
    logic [1:0] priv_reg,   priv_next;
    logic       closed_reg, closed_next;

    logic       accept;
    logic       connect;
    logic [7:0] c;
    logic       fwd_cand;
    logic       fwd;
    logic       lead;
    logic [1:0] lead_len;
    logic [1:0] data_len;
    logic [2:0] seq_n;
    logic [2:0] action;

    assign accept    = in_valid && in_ready;
    assign in_ready  = job_ready;
    assign job_valid = in_valid;
    assign connect   = !mode_reg;
    assign c         = in_data.typed_byte;

    always_comb
    begin
        pend_next   = pend_reg;
        mode_next   = mode_reg;
        echo_next   = echo_reg;
        quiet_next  = quiet_reg;
        priv_next   = priv_reg;
        closed_next = closed_reg;
        fwd_cand    = 1'b0;
        lead        = 1'b0;
        seq_n       = 3'd0;
        action      = ACT_NONE;
        if (in_data.end_of_input)
        begin
            action = ACT_DONE;
        end
        else if (!pend_reg && c == esc_reg)
        begin
            pend_next = 1'b1;
        end
        else
        begin
            pend_next = 1'b0;
            if (!pend_reg)
            begin
                fwd_cand = 1'b1;
            end
            else
            begin
                unique case (c)
                    CMD_BREAK, CMD_DEL:
                    begin
                        if (connect)
                            seq_n = 3'd2;
                    end
                    CMD_CLOSE:
                    begin
                        closed_next = 1'b1;
                        action      = ACT_CLOSE;
                    end
                    CMD_ECHO:
                    begin
                        if (connect)
                        begin
                            echo_next = !echo_reg;
                            action    = ACT_ECHO;
                        end
                    end
                    CMD_FORCE, CMD_JOIN:
                    begin
                        if (!connect)
                        begin
                            mode_next = 1'b0;
                            priv_next = (c == CMD_FORCE) ? PRIV_FORCE : PRIV_JOIN;
                            seq_n     = 3'd2;
                        end
                    end
                    CMD_HELP:
                        action = ACT_HELP;
                    CMD_INFO:
                        action = ACT_INFO;
                    CMD_REPLAY:
                    begin
                        if (!broadcast_reg)
                            seq_n = 3'd2;
                    end
                    CMD_MONITOR:
                    begin
                        if (connect && !broadcast_reg)
                        begin
                            mode_next = 1'b1;
                            priv_next = PRIV_NONE;
                            seq_n     = 3'd2;
                        end
                    end
                    CMD_QUIET:
                    begin
                        quiet_next = !quiet_reg;
                        seq_n      = 3'd2;
                    end
                    CMD_RESET:
                    begin
                        if (connect && reset_allowed_reg)
                            seq_n = 3'd2;
                    end
                    CMD_SUSPEND:
                    begin
                        seq_n  = 3'd4;
                        action = ACT_SUSPEND;
                    end
                    default:
                    begin
                        // unknown command byte goes out behind the escape char, or alone if it is the escape char
                        fwd_cand = 1'b1;
                        lead     = (c != esc_reg);
                    end
                endcase
            end
        end
    end

    // forwarded data: escape char and byte, each doubled when it is the protocol escape
    assign fwd      = fwd_cand && connect;
    assign lead_len = lead ? ((esc_reg == PROTO_ESCAPE) ? 2'd2 : 2'd1) : 2'd0;
    assign data_len = (c == PROTO_ESCAPE) ? 2'd2 : 2'd1;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (fwd)
                job.bytes[k] = (3'(k) < {1'b0, lead_len}) ? esc_reg : c;
            else
                job.bytes[k] = k[0] ? c : PROTO_ESCAPE;
        end
        job.count  = fwd ? ({1'b0, lead_len} + {1'b0, data_len}) : seq_n;
        job.action = action;
        job.mode   = mode_next;
        job.echo   = echo_next;
        job.quiet  = quiet_next;
        job.priv   = priv_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg           <= ESCAPE_CHAR_RST;
            broadcast_reg     <= 1'b0;
            reset_allowed_reg <= 1'b0;
            pend_reg          <= 1'b0;
            mode_reg          <= 1'b0;
            echo_reg          <= 1'b1;
            quiet_reg         <= 1'b0;
            priv_reg          <= PRIV_NONE;
            closed_reg        <= 1'b0;
        end
        else if (cfg_valid)
        begin
            // initial-value registers load their state flag directly
            unique case (cfg_index)
                REG_ESCAPE_CHAR:
                    esc_reg <= cfg_data;
                REG_INITIAL_MONITOR:
                    mode_reg <= cfg_data[0];
                REG_BROADCAST_ON:
                    broadcast_reg <= cfg_data[0];
                REG_RESET_ALLOWED:
                    reset_allowed_reg <= cfg_data[0];
                REG_ECHO_INITIAL:
                    echo_reg <= cfg_data[0];
                REG_QUIET_INITIAL:
                    quiet_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
        else if (accept)
        begin
            pend_reg   <= pend_next;
            mode_reg   <= mode_next;
            echo_reg   <= echo_next;
            quiet_reg  <= quiet_next;
            priv_reg   <= priv_next;
            closed_reg <= closed_next;
        end
    end

    // end of input leaves the session state alone
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_data.end_of_input && !cfg_valid |=>
            $stable(pend_reg) && $stable(mode_reg) && $stable(echo_reg) &&
            $stable(quiet_reg) && $stable(priv_reg))
        else $error("end of input changed session state");

    // escape character with nothing pending arms the escape
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && !cfg_valid && !in_data.end_of_input && !pend_reg &&
            in_data.typed_byte == esc_reg |=> pend_reg)
        else $error("escape character did not arm pending escape");

    // a closed session is never reopened by typed bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        closed_reg |=> closed_reg)
        else $error("closed flag dropped");

endmodule

### rtl/cei_queue.sv
// short job queue between front and back end
// depends on cei_pkg for the job type
module cei_queue #(
    parameter int unsigned DEPTH = cei_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  cei_pkg::job_t push_job,
    output logic          pop_valid,
    input  logic          pop_ready,
    output cei_pkg::job_t pop_job
);
    import cei_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;
    logic             push;
    logic             pop;

    assign push_ready = (cnt_reg != CNT_FULL);
    assign pop_valid  = (cnt_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_job    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_FULL)
        else $error("queue fill beyond depth");

    // pointers agree with the fill count
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == '0 || cnt_reg == CNT_FULL |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers out of step with fill count");

endmodule

### rtl/cei_back.sv
// back end: steps through the bytes of each job, one result transaction
// per cycle while out_ready is high, from a registered job; depends on cei_pkg
module cei_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    output logic               job_ready,
    input  cei_pkg::job_t      job,
    output logic               out_valid,
    input  logic               out_ready,
    output cei_pkg::out_item_t out_data
);
    import cei_pkg::*;

    job_t       cur_reg;
    logic       valid_reg, valid_next;
    logic [1:0] idx_reg,   idx_next;
    logic       is_last;
    logic       load;

    // a job with nothing to send still yields one result
    assign is_last = (cur_reg.count == 3'd0) ||
                     ({1'b0, idx_reg} == cur_reg.count - 3'd1);

    assign job_ready = !valid_reg || (out_ready && is_last);
    assign load      = job_valid && job_ready;
    assign out_valid = valid_reg;

    always_comb
    begin
        out_data.send_valid   = ({1'b0, idx_reg} < cur_reg.count);
        out_data.send_byte    = out_data.send_valid ? cur_reg.bytes[idx_reg] : 8'd0;
        out_data.local_action = (idx_reg == 2'd0) ? cur_reg.action : ACT_NONE;
        out_data.write_mode   = cur_reg.mode;
        out_data.echo_on      = cur_reg.echo;
        out_data.quiet_on     = cur_reg.quiet;
        out_data.privilege    = cur_reg.priv;
        out_data.last         = is_last;
    end

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = 2'd0;
        end
        else if (valid_reg && out_ready)
        begin
            if (is_last)
                valid_next = 1'b0;
            else
                idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            cur_reg <= job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && cur_reg.count != 3'd0 |-> {1'b0, idx_reg} < cur_reg.count)
        else $error("byte index past job length");

    // a taken result that is not last moves on to the next byte of the same job
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && out_ready && !is_last |=>
            valid_reg && idx_reg == $past(idx_reg) + 2'd1)
        else $error("job abandoned before its last result");

endmodule

### tb/sv/console_escape_interpreter_tb.sv
// self-checking testbench for console_escape_interpreter: directed table, then random phases
// depends on cei_pkg and the console_escape_interpreter rtl; checks every result in order
module console_escape_interpreter_tb;
    import cei_pkg::*;

    localparam int N_DIRECTED  = 40;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 120;

    localparam logic [7:0] CMD_LIST [13] = '{CMD_BREAK, CMD_CLOSE, CMD_DEL, CMD_ECHO,
        CMD_FORCE, CMD_HELP, CMD_INFO, CMD_JOIN, CMD_REPLAY, CMD_MONITOR, CMD_QUIET,
        CMD_RESET, CMD_SUSPEND};

    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t want;
    } stim_row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_ready;
    out_item_t  out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;

    // predictor copy of the registers and the session state
    logic [7:0] cfg_esc;
    logic       cfg_init_mon, cfg_bcast, cfg_rst_ok, cfg_echo_init, cfg_quiet_init;
    logic       esc_armed, mon_mode, echo_state, quiet_state, closed_state;
    logic [1:0] priv_state;
    logic [7:0] tx_bytes [4];
    int         tx_count;

    out_item_t  predicted_results [$];
    int         error_count = 0;
    int         result_index = 0;
    int         cycle_count = 0;
    bit         steady;
    bit         hold_req;

    // the rows with a typed-in result sit right after reset, escape '&'
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{{8'hFF, 1'b1}, 1'b1, {1'b0, 8'h00, ACT_DONE, 1'b0, 1'b1, 1'b0, PRIV_NONE, 1'b1}},
        '{{8'h00, 1'b0}, 1'b1, {1'b1, 8'h00, ACT_NONE, 1'b0, 1'b1, 1'b0, PRIV_NONE, 1'b1}},
        '{{8'hFF, 1'b0}, 1'b0, '0},
        '{{ESCAPE_CHAR_RST, 1'b0}, 1'b1,
          {1'b0, 8'h00, ACT_NONE, 1'b0, 1'b1, 1'b0, PRIV_NONE, 1'b1}},
        '{{8'h00, 1'b1}, 1'b1, {1'b0, 8'h00, ACT_DONE, 1'b0, 1'b1, 1'b0, PRIV_NONE, 1'b1}},
        '{{ESCAPE_CHAR_RST, 1'b0}, 1'b0, '0},
        '{{ESCAPE_CHAR_RST, 1'b0}, 1'b0, '0},
        '{{8'hFF, 1'b0}, 1'b0, '0},
        '{{ESCAPE_CHAR_RST, 1'b0}, 1'b0, '0},
        '{{CMD_BREAK, 1'b0}, 1'b0, '0},
        '{{ESCAPE_CHAR_RST, 1'b0}, 1'b0, '0},
        '{{CMD_DEL, 1'b0}, 1'b0, '0},
        '{{ESCAPE_CHAR_RST, 1'b0}, 1'b0, '0},
        '{{CMD_ECHO, 1'b0}, 1'b0, '0},
        '{{ESCAPE_CHAR_RST, 1'b0}, 1'b0, '0},
        '{{CMD_QUIET, 1'b0}, 1'b0, '0},
        '{{ESCAPE_CHAR_RST, 1'b0}, 1'b0, '0},
        '{{CMD_RESET, 1'b0}, 1'b0, '0},
        '{{ESCAPE_CHAR_RST, 1'b0}, 1'b0, '0},
        '{{CMD_REPLAY, 1'b0}, 1'b0, '0},
        '{{ESCAPE_CHAR_RST, 1'b0}, 1'b0, '0},
        '{{CMD_HELP, 1'b0}, 1'b0, '0},
        '{{ESCAPE_CHAR_RST, 1'b0}, 1'b0, '0},
        '{{CMD_INFO, 1'b0}, 1'b0, '0},
        '{{ESCAPE_CHAR_RST, 1'b0}, 1'b0, '0},
        '{{CMD_CLOSE, 1'b0}, 1'b0, '0},
        '{{ESCAPE_CHAR_RST, 1'b0}, 1'b0, '0},
        '{{CMD_SUSPEND, 1'b0}, 1'b0, '0},
        '{{ESCAPE_CHAR_RST, 1'b0}, 1'b0, '0},
        '{{CMD_MONITOR, 1'b0}, 1'b0, '0},
        '{{8'h61, 1'b0}, 1'b0, '0},
        '{{ESCAPE_CHAR_RST, 1'b0}, 1'b0, '0},
        '{{CMD_ECHO, 1'b0}, 1'b0, '0},
        '{{ESCAPE_CHAR_RST, 1'b0}, 1'b0, '0},
        '{{CMD_FORCE, 1'b0}, 1'b0, '0},
        '{{ESCAPE_CHAR_RST, 1'b0}, 1'b0, '0},
        '{{CMD_MONITOR, 1'b0}, 1'b0, '0},
        '{{ESCAPE_CHAR_RST, 1'b0}, 1'b0, '0},
        '{{CMD_JOIN, 1'b0}, 1'b0, '0},
        '{{8'h7F, 1'b0}, 1'b0, '0}
    };

    console_escape_interpreter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    function automatic void push_tx_byte(input logic [7:0] b);
        if (tx_count < 4)
        begin
            tx_bytes[tx_count] = b;
            tx_count++;
        end
    endfunction

    function automatic void push_proto_seq(input logic [7:0] c);
        push_tx_byte(PROTO_ESCAPE);
        push_tx_byte(c);
    endfunction

    // forwarded data doubles every protocol escape byte
    function automatic void push_data_byte(input logic [7:0] b);
        push_tx_byte(b);
        if (b == PROTO_ESCAPE)
            push_tx_byte(b);
    endfunction

    function automatic void interpret_byte(input in_item_t it, input bit queue_results);
        logic [7:0] c;
        logic [2:0] act;
        logic       connect, known, fwd, lead;
        int         n;
        out_item_t  r;
        c = it.typed_byte;
        act = ACT_NONE;
        tx_count = 0;
        if (it.end_of_input)
            act = ACT_DONE;
        else if (!esc_armed && c == cfg_esc)
            esc_armed = 1'b1;
        else
        begin
            fwd = 1'b1;
            lead = 1'b0;
            if (esc_armed)
            begin
                esc_armed = 1'b0;
                connect = !mon_mode;
                known = 1'b1;
                case (c)
                    CMD_BREAK, CMD_DEL:
                        if (connect)
                            push_proto_seq(c);
                    CMD_CLOSE:
                    begin
                        closed_state = 1'b1;
                        act = ACT_CLOSE;
                    end
                    CMD_ECHO:
                        if (connect)
                        begin
                            echo_state = ~echo_state;
                            act = ACT_ECHO;
                        end
                    CMD_FORCE, CMD_JOIN:
                        if (!connect)
                        begin
                            mon_mode = 1'b0;
                            priv_state = (c == CMD_FORCE) ? PRIV_FORCE : PRIV_JOIN;
                            push_proto_seq(c);
                        end
                    CMD_HELP:
                        act = ACT_HELP;
                    CMD_INFO:
                        act = ACT_INFO;
                    CMD_REPLAY:
                        if (!cfg_bcast)
                            push_proto_seq(c);
                    CMD_MONITOR:
                        if (connect && !cfg_bcast)
                        begin
                            mon_mode = 1'b1;
                            priv_state = PRIV_NONE;
                            push_proto_seq(c);
                        end
                    CMD_QUIET:
                    begin
                        quiet_state = ~quiet_state;
                        push_proto_seq(c);
                    end
                    CMD_RESET:
                        if (connect && cfg_rst_ok)
                            push_proto_seq(c);
                    CMD_SUSPEND:
                    begin
                        push_proto_seq(c);
                        push_proto_seq(c);
                        act = ACT_SUSPEND;
                    end
                    default:
                        known = 1'b0;
                endcase
                if (known)
                    fwd = 1'b0;
                else if (c != cfg_esc)
                    lead = 1'b1;
            end
            if (fwd && !mon_mode)
            begin
                if (lead)
                    push_data_byte(cfg_esc);
                push_data_byte(c);
            end
        end
        n = (tx_count > 0) ? tx_count : 1;
        if (queue_results)
            for (int k = 0; k < n; k++)
            begin
                r.send_valid   = (k < tx_count);
                r.send_byte    = (k < tx_count) ? tx_bytes[k] : 8'h00;
                r.local_action = (k == 0) ? act : ACT_NONE;
                r.write_mode   = mon_mode;
                r.echo_on      = echo_state;
                r.quiet_on     = quiet_state;
                r.privilege    = priv_state;
                r.last         = (k == n - 1);
                predicted_results.push_back(r);
            end
    endfunction

    task automatic offer_byte(input in_item_t it, input bit typed, input out_item_t want);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        interpret_byte(it, !typed);
        if (typed)
            predicted_results.push_back(want);
    endtask

    // cfg_valid is left high so back-to-back writes need one assignment per step
    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_ESCAPE_CHAR:
                cfg_esc = val;
            REG_INITIAL_MONITOR:
            begin
                cfg_init_mon = val[0];
                mon_mode = val[0];
            end
            REG_BROADCAST_ON:
                cfg_bcast = val[0];
            REG_RESET_ALLOWED:
                cfg_rst_ok = val[0];
            REG_ECHO_INITIAL:
            begin
                cfg_echo_init = val[0];
                echo_state = val[0];
            end
            REG_QUIET_INITIAL:
            begin
                cfg_quiet_init = val[0];
                quiet_state = val[0];
            end
            default:
                ;
        endcase
    endtask

    task automatic wait_idle();
        while (predicted_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic run_phase(input logic [7:0] esc, input bit mon, input bit bc, input bit rok,
                             input bit echo_i, input bit quiet_i, input int n_items,
                             input bit steady_phase, input bit burst);
        int         sent;
        int         r;
        logic [7:0] second;
        wait_idle();
        write_reg(REG_ESCAPE_CHAR, esc);
        write_reg(REG_INITIAL_MONITOR, {7'd0, mon});
        write_reg(REG_BROADCAST_ON, {7'd0, bc});
        write_reg(REG_RESET_ALLOWED, {7'd0, rok});
        write_reg(REG_ECHO_INITIAL, {7'd0, echo_i});
        write_reg(REG_QUIET_INITIAL, {7'd0, quiet_i});
        cfg_valid <= 1'b0;
        steady    <= steady_phase;
        hold_req  <= burst;
        sent = 0;
        while (sent < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                offer_byte({8'($urandom_range(0, 255)), 1'b1}, 1'b0, '0);
            else if (r < 28)
                offer_byte({8'($urandom_range(0, 255)), 1'b0}, 1'b0, '0);
            else if (r < 36)
                offer_byte({PROTO_ESCAPE, 1'b0}, 1'b0, '0);
            else
            begin
                // escape followed by a command, the escape itself, or noise
                r = $urandom_range(0, 99);
                if (r < 75)
                    second = CMD_LIST[$urandom_range(0, 12)];
                else if (r < 85)
                    second = cfg_esc;
                else
                    second = 8'($urandom_range(0, 255));
                offer_byte({cfg_esc, 1'b0}, 1'b0, '0);
                offer_byte({second, 1'b0}, 1'b0, '0);
                sent++;
            end
            sent++;
        end
        in_valid <= 1'b0;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("result %0d: %s is 0x%0h, expected 0x%0h", result_index, what, got, want);
        error_count++;
    endtask

    // receiver: random stalls, plus one long hold-off so the input side backs up
    initial
    begin
        int stall_left;
        int hold_left;
        bit hold_done;
        stall_left = 0;
        hold_left = 0;
        hold_done = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (steady || $urandom_range(0, 99) < 65)
                out_ready <= 1'b1;
            else
            begin
                stall_left = pick_gap();
                out_ready <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (predicted_results.size() == 0)
                report_mismatch("transaction with nothing expected", out_data, 0);
            else
            begin
                want = predicted_results.pop_front();
                if (out_data.send_valid !== want.send_valid)
                    report_mismatch("send_valid", out_data.send_valid, want.send_valid);
                if (out_data.send_byte !== want.send_byte)
                    report_mismatch("send_byte", out_data.send_byte, want.send_byte);
                if (out_data.local_action !== want.local_action)
                    report_mismatch("local_action", out_data.local_action, want.local_action);
                if (out_data.write_mode !== want.write_mode)
                    report_mismatch("write_mode", out_data.write_mode, want.write_mode);
                if (out_data.echo_on !== want.echo_on)
                    report_mismatch("echo_on", out_data.echo_on, want.echo_on);
                if (out_data.quiet_on !== want.quiet_on)
                    report_mismatch("quiet_on", out_data.quiet_on, want.quiet_on);
                if (out_data.privilege !== want.privilege)
                    report_mismatch("privilege", out_data.privilege, want.privilege);
                if (out_data.last !== want.last)
                    report_mismatch("last", out_data.last, want.last);
            end
            result_index++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_ESCAPE_CHAR;
        cfg_data  <= '0;
        steady    <= 1'b0;
        hold_req  <= 1'b0;

        cfg_esc        = ESCAPE_CHAR_RST;
        cfg_init_mon   = 1'b0;
        cfg_bcast      = 1'b0;
        cfg_rst_ok     = 1'b0;
        cfg_echo_init  = 1'b1;
        cfg_quiet_init = 1'b0;
        esc_armed      = 1'b0;
        mon_mode       = cfg_init_mon;
        echo_state     = cfg_echo_init;
        quiet_state    = cfg_quiet_init;
        priv_state     = PRIV_NONE;
        closed_state   = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            offer_byte(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
        in_valid <= 1'b0;

        // extremes of the escape character, a command character as escape, then random
        run_phase(8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 42, 1'b0, 1'b0);
        run_phase(PROTO_ESCAPE, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 42, 1'b1, 1'b0);
        run_phase(CMD_QUIET, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 42, 1'b0, 1'b1);
        run_phase(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 42, 1'b0, 1'b0);
        run_phase(CMD_LIST[$urandom_range(0, 12)], 1'($urandom_range(0, 1)), 1'b0, 1'b1,
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 42, 1'b0, 1'b0);
        wait_idle();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
